>>> sv/u8tc_pkg.sv
`timescale 1ns / 1ps
// u8tc_pkg: word types, command type and constants for the UTF-8 transcoder.
// No dependencies; used by every module of the block.
package u8tc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_word_t;

    typedef struct packed {
        logic        item_kind;
        logic [20:0] unit_value;
        logic        stream_error;
        logic [16:0] unit_count;
        logic        run_last;
    } out_word_t;

    // One decoded byte: an optional character and an optional end item.
    typedef struct packed {
        logic        has_char;
        logic        pair;
        logic [20:0] char_value;
        logic        has_end;
        logic        end_error;
        logic [16:0] end_count;
    } cmd_t;

    localparam logic KIND_UNIT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int COUNT_LIMIT = 131071;

    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_9F   = 8'h9F;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_8F   = 8'h8F;

    localparam logic [20:0] CP_SUPP    = 21'h010000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SUR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SUR_HI  = 21'h00DFFF;
    localparam logic [20:0] HI_SUR_BASE = 21'h00D800;
    localparam logic [20:0] LO_SUR_BASE = 21'h00DC00;
    localparam logic [9:0]  SUR_MASK    = 10'h3FF;

endpackage

>>> sv/utf8_transcoder.sv
`timescale 1ns / 1ps
// utf8_transcoder: strict UTF-8 to UTF-16 / UTF-32 stream transcoder, top level.
// Each result word passes through the command queue and then the output register.
// Throughput: one byte per cycle while each byte yields at most one word and the receiver
// pops; a byte that yields two or three words holds the single-word output register once
// per word, absorbed by the four-entry queue. Reset clears control state, mode to UTF-16.
module utf8_transcoder #(
    parameter int MAX_UNITS = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  u8tc_pkg::in_word_t  in_word,
    output logic                empty,
    input  logic                pop,
    output u8tc_pkg::out_word_t out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    logic           mode_reg;
    logic           accept;
    u8tc_pkg::cmd_t front_cmd;
    u8tc_pkg::cmd_t head_cmd;
    logic           q_full;
    logic           q_not_empty;
    logic           q_rd;
    logic           q_wr;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;
    assign q_wr      = accept && (front_cmd.has_char || front_cmd.has_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= u8tc_pkg::MODE_UTF16;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    u8tc_front #(
        .MAX_UNITS (MAX_UNITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_word (in_word),
        .mode    (mode_reg),
        .cmd     (front_cmd)
    );

    u8tc_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr),
        .wr_data   (front_cmd),
        .full      (q_full),
        .rd_en     (q_rd),
        .rd_data   (head_cmd),
        .not_empty (q_not_empty)
    );

    u8tc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (q_not_empty),
        .cmd_rd    (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

endmodule

>>> sv/u8tc_front.sv
`timescale 1ns / 1ps
// u8tc_front: per-byte UTF-8 sequence gathering, strict validation and unit counting.
// Depends on u8tc_pkg; produces one cmd_t per accepted byte.
module u8tc_front #(
    parameter int MAX_UNITS = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  u8tc_pkg::in_word_t  in_word,
    input  logic                mode,
    output u8tc_pkg::cmd_t      cmd
);

    localparam int CAP_INT = (MAX_UNITS < u8tc_pkg::COUNT_LIMIT) ? MAX_UNITS
                                                                 : u8tc_pkg::COUNT_LIMIT;
    localparam logic [16:0] CAP = 17'(CAP_INT);

    logic [1:0]  needed_reg, needed_next;
    logic [7:0]  lead_reg, lead_next;
    logic [20:0] accum_reg, accum_next;
    logic        error_reg, error_next;
    logic [16:0] count_reg, count_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [1:0]  total;
        logic        bad;
        logic [20:0] acc_new;
        logic        has_char;
        logic [20:0] cp;
        logic        pair;
        logic [17:0] sum;

        b           = in_word.data_byte;
        total       = 2'd1;
        bad         = 1'b0;
        acc_new     = '0;
        has_char    = 1'b0;
        cp          = '0;
        pair        = 1'b0;
        sum         = '0;
        needed_next = needed_reg;
        lead_next   = lead_reg;
        accum_next  = accum_reg;
        error_next  = error_reg;
        count_next  = count_reg;
        cmd         = '0;

        if (!error_reg)
        begin
            if (needed_reg == 2'd0)
            begin
                if (!b[7])
                begin
                    has_char = 1'b1;
                    cp       = {13'd0, b};
                end
                else if (b >= u8tc_pkg::LEAD2_MIN && b <= u8tc_pkg::LEAD2_MAX)
                begin
                    needed_next = 2'd1;
                    lead_next   = b;
                    accum_next  = {16'd0, b[4:0]};
                end
                else if (b >= u8tc_pkg::LEAD3_MIN && b <= u8tc_pkg::LEAD3_MAX)
                begin
                    needed_next = 2'd2;
                    lead_next   = b;
                    accum_next  = {17'd0, b[3:0]};
                end
                else if (b >= u8tc_pkg::LEAD4_MIN && b <= u8tc_pkg::LEAD4_MAX)
                begin
                    needed_next = 2'd3;
                    lead_next   = b;
                    accum_next  = {18'd0, b[2:0]};
                end
                else
                begin
                    error_next  = 1'b1;
                    needed_next = 2'd0;
                end
            end
            else
            begin
                if (lead_reg >= u8tc_pkg::LEAD4_MIN)
                    total = 2'd3;
                else if (lead_reg >= u8tc_pkg::LEAD3_MIN)
                    total = 2'd2;
                else
                    total = 2'd1;
                bad = (b[7:6] != 2'b10);
                if (needed_reg == total)
                begin
                    if ((lead_reg == u8tc_pkg::LEAD3_MIN && b < u8tc_pkg::CONT_A0) ||
                        (lead_reg == u8tc_pkg::LEAD_ED   && b > u8tc_pkg::CONT_9F) ||
                        (lead_reg == u8tc_pkg::LEAD4_MIN && b < u8tc_pkg::CONT_90) ||
                        (lead_reg == u8tc_pkg::LEAD4_MAX && b > u8tc_pkg::CONT_8F))
                        bad = 1'b1;
                end
                acc_new = {accum_reg[14:0], b[5:0]};
                if (bad)
                begin
                    error_next  = 1'b1;
                    needed_next = 2'd0;
                end
                else
                begin
                    accum_next  = acc_new;
                    needed_next = needed_reg - 2'd1;
                    if (needed_reg == 2'd1)
                    begin
                        if (acc_new > u8tc_pkg::CP_MAX ||
                            (acc_new >= u8tc_pkg::CP_SUR_LO && acc_new <= u8tc_pkg::CP_SUR_HI))
                            error_next = 1'b1;
                        else
                        begin
                            has_char = 1'b1;
                            cp       = acc_new;
                        end
                    end
                end
            end
        end

        if (has_char)
        begin
            pair = (mode == u8tc_pkg::MODE_UTF16) && (cp >= u8tc_pkg::CP_SUPP);
            sum  = {1'b0, count_reg} + (pair ? 18'd2 : 18'd1);
            count_next = (sum >= {1'b0, CAP}) ? CAP : sum[16:0];
        end

        cmd.has_char   = has_char;
        cmd.pair       = pair;
        cmd.char_value = cp;

        if (in_word.end_of_stream)
        begin
            cmd.has_end   = 1'b1;
            cmd.end_error = error_next || (needed_next != 2'd0);
            cmd.end_count = count_next;
            needed_next   = 2'd0;
            lead_next     = '0;
            accum_next    = '0;
            error_next    = 1'b0;
            count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg <= '0;
            lead_reg   <= '0;
            accum_reg  <= '0;
            error_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            needed_reg <= needed_next;
            lead_reg   <= lead_next;
            accum_reg  <= accum_next;
            error_reg  <= error_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_err_clears_seq: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> needed_reg == 2'd0)
        else $error("pending sequence kept after error");
    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("unit count above cap");
`endif

endmodule

>>> sv/u8tc_cmd_fifo.sv
`timescale 1ns / 1ps
// u8tc_cmd_fifo: short command queue between the decode front and the emit back.
// Depends on u8tc_pkg for cmd_t and the queue depth.
module u8tc_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  u8tc_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output u8tc_pkg::cmd_t rd_data,
    output logic           not_empty
);

    u8tc_pkg::cmd_t mem [u8tc_pkg::CMD_DEPTH];

    logic [u8tc_pkg::CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [u8tc_pkg::CMD_CNT_W-1:0] count_reg;

    assign full      = (count_reg == u8tc_pkg::CMD_CNT_W'(u8tc_pkg::CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == u8tc_pkg::CMD_PTR_W'(u8tc_pkg::CMD_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == u8tc_pkg::CMD_PTR_W'(u8tc_pkg::CMD_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full || rd_en)
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> not_empty)
        else $error("command queue underflow");
`endif

endmodule

>>> sv/u8tc_back.sv
`timescale 1ns / 1ps
// u8tc_back: expands queued commands into result words, surrogate split included.
// Depends on u8tc_pkg; holds the output register.
module u8tc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  u8tc_pkg::cmd_t    cmd,
    input  logic              cmd_valid,
    output logic              cmd_rd,
    output logic              empty,
    input  logic              pop,
    output u8tc_pkg::out_word_t out_word
);

    logic [1:0]          step_reg;
    logic                out_valid_reg;
    u8tc_pkg::out_word_t out_reg;

    logic [1:0]          n_char;
    logic [1:0]          n_res;
    logic                last;
    logic                load;
    logic [20:0]         v;
    u8tc_pkg::out_word_t res;

    always_comb
    begin
        n_char = cmd.has_char ? (cmd.pair ? 2'd2 : 2'd1) : 2'd0;
        n_res  = n_char + {1'b0, cmd.has_end};
        last   = (step_reg == n_res - 2'd1);
        v      = cmd.char_value - u8tc_pkg::CP_SUPP;
        res    = '0;
        if (cmd.has_char && step_reg < n_char)
        begin
            res.item_kind = u8tc_pkg::KIND_UNIT;
            if (!cmd.pair)
                res.unit_value = cmd.char_value;
            else if (step_reg == 2'd0)
                res.unit_value = u8tc_pkg::HI_SUR_BASE | {11'd0, v[19:10] & u8tc_pkg::SUR_MASK};
            else
                res.unit_value = u8tc_pkg::LO_SUR_BASE | {11'd0, v[9:0] & u8tc_pkg::SUR_MASK};
        end
        else
        begin
            res.item_kind    = u8tc_pkg::KIND_END;
            res.stream_error = cmd.end_error;
            res.unit_count   = cmd.end_count;
        end
        res.run_last = last;
    end

    assign load     = cmd_valid && (!out_valid_reg || pop);
    assign cmd_rd   = load && last;
    assign empty    = !out_valid_reg;
    assign out_word = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= last ? 2'd0 : step_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= res;
    end

`ifndef SYNTHESIS
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pop && !out_reg.run_last |=> out_valid_reg)
        else $error("run broken before its last word");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for utf8_transcoder, a strict UTF-8 to UTF-16/UTF-32 decoder.
// Depends on u8tc_pkg and utf8_transcoder; predicts every output word from the accepted
// bytes and compares in order, with random sender gaps and receiver stalls.
module tb;

    localparam int UNIT_CAP       = 16;
    localparam int UNIT_LIMIT     = (UNIT_CAP < u8tc_pkg::COUNT_LIMIT) ? UNIT_CAP
                                                                       : u8tc_pkg::COUNT_LIMIT;
    localparam int TARGET_BYTES   = 470;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum int {BAD_LEAD, BAD_CONT, OVERLONG3, SURROGATE, OVERLONG4, TOO_HIGH, CUT_SHORT}
        fault_t;
    typedef enum int {POP_ALWAYS, POP_OFTEN, POP_RARELY, POP_PERIODIC} rx_style_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                push      = 1'b0;
    logic                full;
    u8tc_pkg::in_word_t  in_word   = '0;
    logic                empty;
    logic                pop       = 1'b0;
    u8tc_pkg::out_word_t out_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    // decoder state mirror
    logic        cur_mode   = u8tc_pkg::MODE_UTF16;
    logic [1:0]  need_cnt   = '0;
    logic [7:0]  lead_reg   = '0;
    logic [20:0] cp_acc     = '0;
    logic        bad_stream = 1'b0;
    logic [16:0] unit_total = '0;

    u8tc_pkg::out_word_t batch [0:2];
    int                  batch_n;
    u8tc_pkg::out_word_t expected_words [$];
    u8tc_pkg::out_word_t want_word;
    logic [7:0]          stream_bytes [$];

    int          sent_bytes   = 0;
    int          mismatches   = 0;
    int          burst_left   = 0;
    int          quiet_cycles = 0;
    int          rx_left      = 0;
    rx_style_t   rx_style     = POP_ALWAYS;

    utf8_transcoder #(
        .MAX_UNITS (UNIT_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic add_unit(input logic [20:0] value);
        batch[batch_n] = '{item_kind: u8tc_pkg::KIND_UNIT, unit_value: value,
                           stream_error: 1'b0, unit_count: '0, run_last: 1'b0};
        batch_n++;
        unit_total = (unit_total < UNIT_LIMIT) ? unit_total + 17'd1 : 17'(UNIT_LIMIT);
    endtask

    task automatic add_char(input logic [20:0] cp);
        logic [20:0] off;
        if (cur_mode == u8tc_pkg::MODE_UTF16 && cp >= u8tc_pkg::CP_SUPP)
        begin
            off = cp - u8tc_pkg::CP_SUPP;
            add_unit(u8tc_pkg::HI_SUR_BASE | {11'd0, off[19:10] & u8tc_pkg::SUR_MASK});
            add_unit(u8tc_pkg::LO_SUR_BASE | {11'd0, off[9:0] & u8tc_pkg::SUR_MASK});
        end
        else
            add_unit(cp);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [1:0] total;
        logic       bad;
        batch_n = 0;
        sent_bytes++;
        if (!bad_stream)
        begin
            if (need_cnt == 2'd0)
            begin
                if (!b[7])
                    add_char({13'd0, b});
                else if (b >= u8tc_pkg::LEAD2_MIN && b <= u8tc_pkg::LEAD2_MAX)
                begin
                    need_cnt = 2'd1;
                    lead_reg = b;
                    cp_acc   = {16'd0, b[4:0]};
                end
                else if (b >= u8tc_pkg::LEAD3_MIN && b <= u8tc_pkg::LEAD3_MAX)
                begin
                    need_cnt = 2'd2;
                    lead_reg = b;
                    cp_acc   = {17'd0, b[3:0]};
                end
                else if (b >= u8tc_pkg::LEAD4_MIN && b <= u8tc_pkg::LEAD4_MAX)
                begin
                    need_cnt = 2'd3;
                    lead_reg = b;
                    cp_acc   = {18'd0, b[2:0]};
                end
                else
                    bad_stream = 1'b1;
            end
            else
            begin
                total = (lead_reg >= u8tc_pkg::LEAD4_MIN) ? 2'd3 :
                        (lead_reg >= u8tc_pkg::LEAD3_MIN) ? 2'd2 : 2'd1;
                bad   = (b[7:6] != 2'b10);
                if (!bad && need_cnt == total)
                    bad = (lead_reg == u8tc_pkg::LEAD3_MIN && b < u8tc_pkg::CONT_A0) ||
                          (lead_reg == u8tc_pkg::LEAD_ED && b > u8tc_pkg::CONT_9F) ||
                          (lead_reg == u8tc_pkg::LEAD4_MIN && b < u8tc_pkg::CONT_90) ||
                          (lead_reg == u8tc_pkg::LEAD4_MAX && b > u8tc_pkg::CONT_8F);
                if (bad)
                begin
                    bad_stream = 1'b1;
                    need_cnt   = 2'd0;
                end
                else
                begin
                    cp_acc   = {cp_acc[14:0], b[5:0]};
                    need_cnt = need_cnt - 2'd1;
                    if (need_cnt == 2'd0)
                    begin
                        if (cp_acc > u8tc_pkg::CP_MAX ||
                            (cp_acc >= u8tc_pkg::CP_SUR_LO && cp_acc <= u8tc_pkg::CP_SUR_HI))
                            bad_stream = 1'b1;
                        else
                            add_char(cp_acc);
                    end
                end
            end
        end
        if (eos)
        begin
            if (need_cnt != 2'd0)
                bad_stream = 1'b1;
            batch[batch_n] = '{item_kind: u8tc_pkg::KIND_END, unit_value: '0,
                               stream_error: bad_stream, unit_count: unit_total,
                               run_last: 1'b0};
            batch_n++;
            need_cnt   = '0;
            lead_reg   = '0;
            cp_acc     = '0;
            bad_stream = 1'b0;
            unit_total = '0;
        end
        if (batch_n > 0)
            batch[batch_n - 1].run_last = 1'b1;
        for (int i = 0; i < batch_n; i++)
            expected_words.push_back(batch[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                if (push)
                    push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        if (!push)
            push <= 1'b1;
        in_word <= '{data_byte: b, end_of_stream: eos};
        do @(posedge clk); while (full);
        decode_byte(b, eos);
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    // hold the sender until every predicted word has been popped
    task automatic wait_all_words();
        if (push)
            push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_all_words();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    function automatic logic [7:0] any_continuation();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] not_continuation();
        logic [1:0] top;
        top = 2'($urandom_range(0, 2));
        if (top == 2'b10)
            top = 2'b11;
        return {top, 6'($urandom)};
    endfunction

    function automatic logic [20:0] random_code(input bit multi);
        logic [20:0] edges [0:9] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF,
                                     21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF};
        logic [20:0] cp;
        if (!multi && $urandom_range(0, 9) == 0)
            return edges[$urandom_range(0, 9)];
        case ($urandom_range(multi ? 1 : 0, 3))
            0: cp = 21'($urandom_range(0, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2:
            begin
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= u8tc_pkg::CP_SUR_LO)
                    cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    task automatic put_code(input logic [20:0] cp);
        if (cp < 21'h80)
            stream_bytes.push_back(cp[7:0]);
        else if (cp < 21'h800)
        begin
            stream_bytes.push_back({3'b110, cp[10:6]});
            stream_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < u8tc_pkg::CP_SUPP)
        begin
            stream_bytes.push_back({4'b1110, cp[15:12]});
            stream_bytes.push_back({2'b10, cp[11:6]});
            stream_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            stream_bytes.push_back({5'b11110, cp[20:18]});
            stream_bytes.push_back({2'b10, cp[17:12]});
            stream_bytes.push_back({2'b10, cp[11:6]});
            stream_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    // multi-byte character with its tail cut off
    task automatic put_cut_code();
        int mark;
        mark = stream_bytes.size();
        put_code(random_code(1));
        repeat ($urandom_range(1, stream_bytes.size() - mark - 1))
            void'(stream_bytes.pop_back());
    endtask

    task automatic put_broken();
        fault_t fault;
        int     len;
        int     pos;
        fault = fault_t'($urandom_range(0, 6));
        case (fault)
            BAD_LEAD:
                stream_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                                            : 8'($urandom_range('hF5, 'hFF)));
            BAD_CONT:
            begin
                len = $urandom_range(1, 3);
                stream_bytes.push_back(
                    len == 1 ? 8'($urandom_range(u8tc_pkg::LEAD2_MIN, u8tc_pkg::LEAD2_MAX)) :
                    len == 2 ? 8'($urandom_range(u8tc_pkg::LEAD3_MIN, u8tc_pkg::LEAD3_MAX)) :
                               8'($urandom_range(u8tc_pkg::LEAD4_MIN, u8tc_pkg::LEAD4_MAX)));
                pos = $urandom_range(0, len - 1);
                for (int i = 0; i < len; i++)
                    stream_bytes.push_back(i == pos ? not_continuation() : any_continuation());
            end
            OVERLONG3:
            begin
                stream_bytes.push_back(u8tc_pkg::LEAD3_MIN);
                stream_bytes.push_back(8'($urandom_range('h80, u8tc_pkg::CONT_9F)));
                stream_bytes.push_back(any_continuation());
            end
            SURROGATE:
            begin
                stream_bytes.push_back(u8tc_pkg::LEAD_ED);
                stream_bytes.push_back(8'($urandom_range(u8tc_pkg::CONT_A0, 'hBF)));
                stream_bytes.push_back(any_continuation());
            end
            OVERLONG4:
            begin
                stream_bytes.push_back(u8tc_pkg::LEAD4_MIN);
                stream_bytes.push_back(8'($urandom_range('h80, u8tc_pkg::CONT_8F)));
                stream_bytes.push_back(any_continuation());
                stream_bytes.push_back(any_continuation());
            end
            TOO_HIGH:
            begin
                stream_bytes.push_back(u8tc_pkg::LEAD4_MAX);
                stream_bytes.push_back(8'($urandom_range(u8tc_pkg::CONT_90, 'hBF)));
                stream_bytes.push_back(any_continuation());
                stream_bytes.push_back(any_continuation());
            end
            default:
                put_cut_code();
        endcase
    endtask

    task automatic test_valid_forms();
        stream_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                         8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                         8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_stream();
    endtask

    task automatic test_error_handling();
        stream_bytes = '{8'h41, 8'hED, 8'hA0, 8'h42, 8'h43};
        send_stream();
        stream_bytes = '{8'hE0};
        send_stream();
        stream_bytes = '{8'hC1, 8'h41};
        send_stream();
    endtask

    task automatic test_mode_switch();
        write_mode(u8tc_pkg::MODE_UTF32);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        write_mode(u8tc_pkg::MODE_UTF16);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_random_streams();
        int chars;
        while (sent_bytes < TARGET_BYTES)
        begin
            if ($urandom_range(0, 5) == 0)
                write_mode($urandom_range(0, 1) ? u8tc_pkg::MODE_UTF32 : u8tc_pkg::MODE_UTF16);
            stream_bytes.delete();
            chars = ($urandom_range(0, 6) == 0) ? $urandom_range(12, 22) : $urandom_range(1, 8);
            repeat (chars)
            begin
                if ($urandom_range(0, 9) == 0)
                    put_broken();
                else
                    put_code(random_code(0));
            end
            if ($urandom_range(0, 4) == 0)
                put_cut_code();
            send_stream();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_valid_forms();
        test_error_handling();
        test_mode_switch();
        test_random_streams();
        wait_all_words();
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // output checker and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d value %h err %0d count %0d last %0d",
                             out_word.item_kind, out_word.unit_value, out_word.stream_error,
                             out_word.unit_count, out_word.run_last);
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (out_word.item_kind !== want_word.item_kind ||
                    out_word.unit_value !== want_word.unit_value ||
                    out_word.stream_error !== want_word.stream_error ||
                    out_word.unit_count !== want_word.unit_count ||
                    out_word.run_last !== want_word.run_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("word mismatch: got kind %0d value %h err %0d count %0d last %0d",
                                 out_word.item_kind, out_word.unit_value,
                                 out_word.stream_error, out_word.unit_count, out_word.run_last);
                        $display("               want kind %0d value %h err %0d count %0d last %0d",
                                 want_word.item_kind, want_word.unit_value,
                                 want_word.stream_error, want_word.unit_count,
                                 want_word.run_last);
                    end
                end
            end
        end
        if (rx_left == 0)
        begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            rx_left  = $urandom_range(8, 80);
        end
        else
            rx_left--;
        case (rx_style)
            POP_ALWAYS:   pop <= 1'b1;
            POP_OFTEN:    pop <= ($urandom_range(0, 3) != 0);
            POP_RARELY:   pop <= ($urandom_range(0, 3) == 0);
            default:      pop <= (rx_left % 8 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

endmodule

>>> files.f
sv/u8tc_pkg.sv
sv/u8tc_front.sv
sv/u8tc_cmd_fifo.sv
sv/u8tc_back.sv
sv/utf8_transcoder.sv
tb/tb.sv
